// ===== sv/base64_stream_decoder_top_assert.svh =====
// Assertion macros shared by the base64 stream decoder RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`define BASE64_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/b64d_pkg.sv =====
// Shared types, constants and the alphabet lookup of the base64 stream decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package b64d_pkg;

  localparam logic [7:0] CharPad = 8'h3D;  // '='

  typedef enum logic {
    KindData   = 1'b0,
    KindFinish = 1'b1
  } kind_e;

  // One queued unit of output work: one to three results that share flags.
  typedef struct packed {
    logic [23:0] bytes;      // first result in the top byte
    logic [1:0]  num;        // number of results, 1 to 3
    logic        byte_valid;
    logic        err;
    logic        garb;
    logic        ended;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  // Maps a character of the standard alphabet to its six-bit value.
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.ok    = 1'b1;
    r.value = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_front.sv =====
// Front end of the base64 stream decoder: accepts characters, keeps the sextet
// accumulator and the sticky flags, and queues work entries. Uses b64d_pkg.
`default_nettype none
`include "base64_stream_decoder_top_assert.svh"

module b64d_front import b64d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] in_char_i,
  input  wire logic       full_i,
  output logic            push_o,
  output entry_t          entry_o
);

  logic [17:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        ended_q, ended_d;
  logic        err_q, err_d;
  logic        garb_q, garb_d;
  logic        accept;
  logic        push_req;
  logic [23:0] bytes;
  logic [1:0]  num;
  logic        bv;
  logic [17:0] acc_new;
  sextet_t     sx;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign sx         = sextet_of(in_char_i);
  assign acc_new    = {acc_q[11:0], sx.value};

  always_comb begin
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    ended_d  = ended_q;
    err_d    = err_q;
    garb_d   = garb_q;
    push_req = 1'b0;
    bytes    = '0;
    num      = 2'd1;
    bv       = 1'b0;
    if (ended_q) begin
      // Every item after the end gives exactly one status result.
      push_req = 1'b1;
      if (kind_e'(kind_i) == KindData && in_char_i != 8'h00) begin
        garb_d = 1'b1;
      end
    end else if (kind_e'(kind_i) == KindFinish || in_char_i == CharPad) begin
      ended_d  = 1'b1;
      acc_d    = '0;
      cnt_d    = '0;
      push_req = 1'b1;
      unique case (cnt_q)
        2'd3: begin
          bytes = {acc_q[17:10], acc_q[9:2], 8'h00};
          num   = 2'd2;
          bv    = 1'b1;
        end
        2'd2: begin
          bytes = {acc_q[11:4], 16'h0000};
          bv    = 1'b1;
        end
        2'd1: begin
          err_d = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (!sx.ok) begin
      err_d = 1'b1;
    end else if (cnt_q == 2'd3) begin
      push_req = 1'b1;
      bytes    = {acc_q, sx.value};
      num      = 2'd3;
      bv       = 1'b1;
      acc_d    = '0;
      cnt_d    = '0;
    end else begin
      acc_d = acc_new;
      cnt_d = cnt_q + 2'd1;
    end
  end

  assign push_o           = accept && push_req;
  assign entry_o.bytes      = bytes;
  assign entry_o.num        = num;
  assign entry_o.byte_valid = bv;
  assign entry_o.err        = err_d;
  assign entry_o.garb       = garb_d;
  assign entry_o.ended      = ended_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      cnt_q   <= '0;
      ended_q <= 1'b0;
      err_q   <= 1'b0;
      garb_q  <= 1'b0;
    end else if (accept) begin
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      ended_q <= ended_d;
      err_q   <= err_d;
      garb_q  <= garb_d;
    end
  end

  // Once the stream has ended, the sextet state stays empty and the end sticks.
  `B64D_ASSERT_NEXT(a_end_sticky, clk_i, rst_ni, ended_q,
                    ended_q && cnt_q == 2'd0, "stream end was lost or sextets gathered after it")

endmodule

`default_nettype wire

// ===== sv/b64d_fifo.sv =====
// Short queue of work entries between the front and back ends of the decoder.
// Uses entry_t from b64d_pkg.
`default_nettype none
`include "base64_stream_decoder_top_assert.svh"

module b64d_fifo import b64d_pkg::*; #(
  parameter int Depth = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t data_i,
  input  wire logic   pop_i,
  output entry_t      data_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `B64D_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, push_i, !full_o || pop_i,
                   "entry written into a full queue")
  `B64D_ASSERT_NOW(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o,
                   "entry read from an empty queue")

endmodule

`default_nettype wire

// ===== sv/b64d_back.sv =====
// Back end of the decoder: takes work entries from the queue and delivers their
// results one per ready cycle from an output register. Uses b64d_pkg.
`default_nettype none
`include "base64_stream_decoder_top_assert.svh"

module b64d_back import b64d_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire entry_t entry_i,
  input  wire logic   empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        last_o,
  output logic        error_seen_o,
  output logic        garbage_seen_o,
  output logic        stream_ended_o
);

  logic [1:0]  rem_q;
  logic [23:0] bytes_q;
  logic        bv_q, err_q, garb_q, ended_q;
  logic        out_accept;

  assign out_valid_o = rem_q != 2'd0;
  assign out_accept  = out_valid_o && out_ready_i;
  // The next entry is loaded as the final result of the current one leaves.
  assign pop_o = !empty_i && (rem_q == 2'd0 || (rem_q == 2'd1 && out_ready_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (pop_o) begin
      rem_q <= entry_i.num;
    end else if (out_accept) begin
      rem_q <= rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bytes_q <= entry_i.bytes;
      bv_q    <= entry_i.byte_valid;
      err_q   <= entry_i.err;
      garb_q  <= entry_i.garb;
      ended_q <= entry_i.ended;
    end else if (out_accept) begin
      bytes_q <= {bytes_q[15:0], 8'h00};
    end
  end

  assign out_byte_o     = bytes_q[23:16];
  assign byte_valid_o   = bv_q;
  assign last_o         = rem_q == 2'd1;
  assign error_seen_o   = err_q;
  assign garbage_seen_o = garb_q;
  assign stream_ended_o = ended_q;

  // A status result always stands alone and carries a zero byte.
  `B64D_ASSERT_NOW(a_status_alone, clk_i, rst_ni, out_valid_o && !byte_valid_o,
                   last_o && out_byte_o == 8'h00, "status result is not a lone zero result")

endmodule

`default_nettype wire

// ===== sv/base64_stream_decoder_top.sv =====
// Base64 stream decoder. One character (or a finish request) is accepted per
// cycle while the internal queue of FifoDepth entries has room; the front end
// classifies it in the cycle of acceptance, and a request that releases results
// reaches the output through the queue and the back end's output register. The
// back end delivers one result per cycle from its output register while the
// output is ready, so four characters give three bytes and a steady stream
// runs at one character per cycle; output stalls reach the input only once the
// queue is full. Characters outside the alphabet set a sticky error flag and
// are dropped; '=' or a finish request flushes leftover sextets and ends the
// stream. Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
`default_nettype none

module base64_stream_decoder_top import b64d_pkg::*; #(
  parameter int FifoDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] in_char_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            last_o,
  output logic            error_seen_o,
  output logic            garbage_seen_o,
  output logic            stream_ended_o
);

  entry_t wr_entry, rd_entry;
  logic   push, pop, full, empty;

  b64d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .in_char_i  (in_char_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (wr_entry)
  );

  b64d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wr_entry),
    .pop_i   (pop),
    .data_o  (rd_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  b64d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (rd_entry),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_o         (last_o),
    .error_seen_o   (error_seen_o),
    .garbage_seen_o (garbage_seen_o),
    .stream_ended_o (stream_ended_o)
  );

endmodule

`default_nettype wire
